[design/jsma_pkg.sv]
// Shared constants, state encoding and lane control bundle for the joint
// state moving average block. No dependencies; jsma_lane and the top level import it.
package jsma_pkg;

  // Joints, window size and the quantities carried by one sample
  localparam int JOINT_COUNT = 7;
  localparam int JOINT_BITS  = 3;
  localparam int WINDOW_MAX  = 64;
  localparam int LANES       = 5;

  // Counts run 0..WINDOW_MAX, ring slots 0..WINDOW_MAX-1
  localparam int COUNT_BITS = $clog2(WINDOW_MAX + 1);
  localparam int SLOT_BITS  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int RING_DEPTH = JOINT_COUNT * WINDOW_MAX;
  localparam int ADDR_BITS  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  // Quotient bits resolved per divider cycle
  localparam int DIV_STEP = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_DIVIDE,
    ST_DONE
  } jsma_state_t;

  // Control shared by all lanes
  typedef struct packed {
    logic                  rd;     // read the oldest ring entry, capture sample
    logic                  wr;     // update sums, write ring, start divider
    logic                  clear;  // empty the history
    logic                  full;   // window already full for this joint
    logic [JOINT_BITS-1:0] joint;
    logic [ADDR_BITS-1:0]  addr;
    logic [COUNT_BITS-1:0] count;  // samples held after this one
  } lane_ctl_t;

endpackage

[design/jsma_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module jsma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 448
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[rd_addr];
    end
  end

endmodule

[design/jsma_div.sv]
// Signed by unsigned divider, truncating toward zero, several quotient bits
// per cycle on a narrow remainder. Depends on nothing but its parameters.
module jsma_div #(
  parameter int DIVIDEND_BITS = 38,
  parameter int DIVISOR_BITS  = 7,
  parameter int STEP          = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]         divisor,
  output logic                            done,
  output logic signed [DIVIDEND_BITS-1:0] quotient
);

  localparam int ROUNDS   = (DIVIDEND_BITS + STEP - 1) / STEP;
  localparam int PAD_BITS = ROUNDS * STEP;
  localparam int CNT_BITS = $clog2(ROUNDS + 1);

  logic [PAD_BITS-1:0]      shreg;
  logic [PAD_BITS-1:0]      sh_next;
  logic [DIVISOR_BITS-1:0]  rem;
  logic [DIVISOR_BITS-1:0]  rem_next;
  logic [DIVISOR_BITS-1:0]  dvs;
  logic [DIVIDEND_BITS-1:0] mag;
  logic [CNT_BITS-1:0]      cnt;
  logic                     neg;
  logic                     busy;

  assign mag = dividend[DIVIDEND_BITS-1] ? DIVIDEND_BITS'(-dividend) : dividend;

  // Long division: shift a dividend bit into the remainder, subtract if it fits
  always_comb begin
    logic [DIVISOR_BITS:0] trial;
    sh_next  = shreg;
    rem_next = rem;
    trial    = '0;
    for (int k = 0; k < STEP; k++) begin
      trial   = {rem_next, sh_next[PAD_BITS-1]};
      sh_next = {sh_next[PAD_BITS-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial      = trial - {1'b0, dvs};
        sh_next[0] = 1'b1;
      end
      rem_next = trial[DIVISOR_BITS-1:0];
    end
  end

  // Sequence the rounds and apply the sign at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      cnt   <= CNT_BITS'(ROUNDS);
      neg   <= dividend[DIVIDEND_BITS-1];
      dvs   <= divisor;
      rem   <= '0;
      shreg <= PAD_BITS'(mag);
    end else if (busy) begin
      shreg <= sh_next;
      rem   <= rem_next;
      cnt   <= cnt - 1'b1;
      if (cnt == CNT_BITS'(1)) begin
        busy     <= 1'b0;
        done     <= 1'b1;
        quotient <= neg ? -$signed(sh_next[DIVIDEND_BITS-1:0])
                        :  $signed(sh_next[DIVIDEND_BITS-1:0]);
      end
    end
  end

endmodule

[design/jsma_lane.sv]
// One quantity's lane: ring memory, per-joint running sums and a divider.
// Depends on jsma_pkg, jsma_ram and jsma_div.
module jsma_lane #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  jsma_pkg::lane_ctl_t           ctl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [SAMPLE_BITS-1:0] mean,
  output logic                          done
);

  import jsma_pkg::*;

  localparam int SUM_BITS = SAMPLE_BITS + SLOT_BITS;

  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic signed [SAMPLE_BITS-1:0] oldest;
  logic signed [SUM_BITS-1:0]    sums [JOINT_COUNT];
  logic signed [SUM_BITS-1:0]    sum_next;
  logic signed [SUM_BITS-1:0]    quotient;

  jsma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk     (clk),
    .we      (ctl.wr),
    .wr_addr (ctl.addr),
    .wdata   (sample_q),
    .re      (ctl.rd),
    .rd_addr (ctl.addr),
    .rdata   (oldest)
  );

  // Hold the accepted sample until the ring write
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      sample_q <= sample;
    end
  end

  // Drop the oldest sample once the window is full, add the new one
  always_comb begin
    sum_next = sums[ctl.joint] + SUM_BITS'(sample_q);
    if (ctl.full) begin
      sum_next = sum_next - SUM_BITS'(oldest);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int i = 0; i < JOINT_COUNT; i++) begin
        sums[i] <= '0;
      end
    end else if (ctl.wr) begin
      sums[ctl.joint] <= sum_next;
    end
  end

  jsma_div #(
    .DIVIDEND_BITS (SUM_BITS),
    .DIVISOR_BITS  (COUNT_BITS),
    .STEP          (DIV_STEP)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.wr),
    .dividend (sum_next),
    .divisor  (ctl.count),
    .done     (done),
    .quotient (quotient)
  );

  // The mean of samples always fits the sample width
  assign mean = quotient[SAMPLE_BITS-1:0];

endmodule

[design/joint_state_moving_average.sv]
// Per-joint windowed moving average of five joint-state quantities.
// Depends on jsma_pkg and jsma_lane (which uses jsma_ram and jsma_div).

// One sample is taken at a time. The oldest ring entry is read at the edge
// that accepts a sample. The block then updates the sums and writes the ring
// in ST_READ, runs the lane dividers (eight quotient bits per cycle) in
// ST_DIVIDE until they all finish, loads the output register in ST_DONE
// and returns to ST_IDLE, ready for the next sample. A stalled result side
// holds the block in ST_DONE until the output register is free. The next
// sample is accepted while a finished result still waits in the output
// register. A sample whose joint index is 7 or higher is accepted and dropped
// without a result. A write of window_length (0 reads as 1, values above 64
// as 64) empties every joint's history at once. Ring memories need no
// clearing pass: an entry's value is used only after it was written.
module joint_state_moving_average #(
  parameter int SAMPLE_BITS = 32
) (
  input  logic                                          clk,
  input  logic                                          rst,
  // Window length register
  input  logic                                          cfg_we,
  input  logic [jsma_pkg::COUNT_BITS-1:0]               cfg_wdata,
  // Input samples
  input  logic                                          s_tvalid,
  output logic                                          s_tready,
  // s_tdata: meas_pos, cmd_pos, meas_trq, cmd_trq, ext_trq
  input  logic [((jsma_pkg::LANES*SAMPLE_BITS+7)/8)*8-1:0] s_tdata,
  // s_tuser: joint_index
  input  logic [jsma_pkg::JOINT_BITS-1:0]               s_tuser,
  // Output means
  output logic                                          m_tvalid,
  input  logic                                          m_tready,
  // m_tdata: means of meas_pos, cmd_pos, meas_trq, cmd_trq, ext_trq,
  //          then samples_held
  output logic [((jsma_pkg::LANES*SAMPLE_BITS+jsma_pkg::COUNT_BITS+7)/8)*8-1:0] m_tdata,
  // m_tuser: joint_out
  output logic [jsma_pkg::JOINT_BITS-1:0]               m_tuser
);

  import jsma_pkg::*;

  localparam int OUT_BITS = ((LANES * SAMPLE_BITS + COUNT_BITS + 7) / 8) * 8;

  jsma_state_t state, state_next;

  logic [COUNT_BITS-1:0] window_length;
  logic [COUNT_BITS-1:0] fill_count [JOINT_COUNT];
  logic [SLOT_BITS-1:0]  write_slot [JOINT_COUNT];

  logic [JOINT_BITS-1:0] joint_q;
  logic [SLOT_BITS-1:0]  slot_q;
  logic                  full_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [ADDR_BITS-1:0]  addr_q;

  logic                  accept;
  logic                  joint_ok;
  logic [SLOT_BITS-1:0]  slot_calc;
  logic                  full_calc;
  logic [COUNT_BITS-1:0] count_calc;
  logic [ADDR_BITS-1:0]  addr_calc;
  logic [COUNT_BITS-1:0] slot_inc;
  logic [COUNT_BITS-1:0] window_next;
  logic                  out_load;
  logic [OUT_BITS-1:0]   out_word;

  lane_ctl_t                     lane_ctl;
  logic signed [SAMPLE_BITS-1:0] lane_mean [LANES];
  logic [LANES-1:0]              lane_done;

  assign accept   = s_tvalid && s_tready;
  assign joint_ok = s_tuser < JOINT_BITS'(JOINT_COUNT);

  // Locate this joint's ring slot and the count after the new sample
  always_comb begin
    slot_calc  = write_slot[s_tuser];
    if (COUNT_BITS'(slot_calc) >= window_length) begin
      slot_calc = '0;
    end
    full_calc  = fill_count[s_tuser] >= window_length;
    count_calc = full_calc ? fill_count[s_tuser] : fill_count[s_tuser] + 1'b1;
    addr_calc  = ADDR_BITS'(s_tuser * WINDOW_MAX) + ADDR_BITS'(slot_calc);
  end

  // Clamp the written window length to 1..WINDOW_MAX
  always_comb begin
    window_next = cfg_wdata;
    if (cfg_wdata == '0) begin
      window_next = COUNT_BITS'(1);
    end else if (cfg_wdata > COUNT_BITS'(WINDOW_MAX)) begin
      window_next = COUNT_BITS'(WINDOW_MAX);
    end
  end

  assign slot_inc = COUNT_BITS'(slot_q) + 1'b1;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && joint_ok) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (&lane_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_tready       = 1'b0;
    out_load       = 1'b0;
    lane_ctl       = '0;
    lane_ctl.clear = cfg_we;
    lane_ctl.full  = full_q;
    lane_ctl.joint = joint_q;
    lane_ctl.count = count_q;
    lane_ctl.addr  = addr_q;
    unique case (state)
      ST_IDLE: begin
        s_tready      = 1'b1;
        lane_ctl.rd   = s_tvalid && joint_ok;
        lane_ctl.addr = addr_calc;
      end
      ST_READ: begin
        lane_ctl.wr = 1'b1;
      end
      ST_DIVIDE: begin
      end
      ST_DONE: begin
        out_load = !m_tvalid || m_tready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the accepted sample's bookkeeping
  always_ff @(posedge clk) begin
    if (accept && joint_ok) begin
      joint_q <= s_tuser;
      slot_q  <= slot_calc;
      full_q  <= full_calc;
      count_q <= count_calc;
      addr_q  <= addr_calc;
    end
  end

  // Window length, fill counts and write slots
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= COUNT_BITS'(1);
      for (int i = 0; i < JOINT_COUNT; i++) begin
        fill_count[i] <= '0;
        write_slot[i] <= '0;
      end
    end else if (cfg_we) begin
      window_length <= window_next;
      for (int i = 0; i < JOINT_COUNT; i++) begin
        fill_count[i] <= '0;
        write_slot[i] <= '0;
      end
    end else if (state == ST_READ) begin
      fill_count[joint_q] <= count_q;
      write_slot[joint_q] <= (slot_inc >= window_length) ? '0 : slot_inc[SLOT_BITS-1:0];
    end
  end

  // Lanes, one per quantity
  for (genvar c = 0; c < LANES; c++) begin : g_lane
    jsma_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ctl    (lane_ctl),
      .sample (s_tdata[c*SAMPLE_BITS +: SAMPLE_BITS]),
      .mean   (lane_mean[c]),
      .done   (lane_done[c])
    );
  end

  // Pack lane means and the held count, padding with zeros
  always_comb begin
    out_word = '0;
    for (int c = 0; c < LANES; c++) begin
      out_word[c*SAMPLE_BITS +: SAMPLE_BITS] = lane_mean[c];
    end
    out_word[LANES*SAMPLE_BITS +: COUNT_BITS] = count_q;
  end

  // Merge lane means into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_word;
      m_tuser <= joint_q;
    end
  end

  // Loading a result always leaves a valid transfer and a free sequencer
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid && state == ST_IDLE)
    else $error("result load did not raise m_tvalid");

  // All lanes finish their division together
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    (lane_done != '0) |-> (lane_done == '1))
    else $error("lane dividers out of step");

  // A joint never holds more samples than the window
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ && !cfg_we) |=> fill_count[joint_q] <= window_length)
    else $error("fill count exceeds window length");

  // Only real joints produce results
  a_joint_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser < JOINT_BITS'(JOINT_COUNT))
    else $error("result for a joint out of range");

endmodule
